[src/mcfir_pkg.sv]
// mcfir_pkg: shared types and constants of the multichannel fir filter
// depends on nothing; used by the interfaces, controller, datapath and top level
`timescale 1ns / 1ps

package mcfir_pkg;

   // field widths of the channel items and the register
   localparam int REQ_TYPE_W  = 1;
   localparam int COEF_IDX_W  = 5;
   localparam int COEF_W      = 16;
   localparam int SAMPLE_W    = 16;
   localparam int RESULT_W    = 24;
   localparam int TAP_COUNT_W = 6;

   // arithmetic widths
   localparam int PROD_W = COEF_W + SAMPLE_W;
   localparam int ACC_W  = 40;
   localparam int FRAC_W = 15;

   // request kinds
   localparam logic [REQ_TYPE_W-1:0] REQ_COEF   = 1'b0;
   localparam logic [REQ_TYPE_W-1:0] REQ_SAMPLE = 1'b1;

   // reset value of the tap count register
   localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 6'd1;

   // controller states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic accept_coef;
      logic accept_sample;
      logic step;
      logic load_out;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic zero_taps;
      logic last_tap;
      logic pipe_busy;
      logic out_free;
   } status_type;

endpackage

[src/mcfir_req_if.sv]
// mcfir_req_if: request channel carrying coefficient writes and samples
// depends on mcfir_pkg for field widths
`timescale 1ns / 1ps

interface mcfir_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [mcfir_pkg::REQ_TYPE_W-1:0]         req_type;
   logic [mcfir_pkg::COEF_IDX_W-1:0]         coef_index;
   logic signed [mcfir_pkg::COEF_W-1:0]      coef_value;
   logic signed [mcfir_pkg::SAMPLE_W-1:0]    sample_value;
   logic                                     channel_start;

   modport source (
      output valid, req_type, coef_index, coef_value, sample_value, channel_start,
      input  ready
   );

   modport sink (
      input  valid, req_type, coef_index, coef_value, sample_value, channel_start,
      output ready
   );
endinterface

[src/mcfir_rsp_if.sv]
// mcfir_rsp_if: result channel carrying one filtered value per sample
// depends on mcfir_pkg for field widths
`timescale 1ns / 1ps

interface mcfir_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [mcfir_pkg::RESULT_W-1:0]    filtered_value;

   modport source (
      output valid, filtered_value,
      input  ready
   );

   modport sink (
      input  valid, filtered_value,
      output ready
   );
endinterface

[src/mcfir_ctrl.sv]
// mcfir_ctrl: sequencer that accepts items and steps the shared mac over the taps
// depends on mcfir_pkg for state, command and status types
`timescale 1ns / 1ps

module mcfir_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic [mcfir_pkg::REQ_TYPE_W-1:0]      req_type,
   output logic                                  req_ready,
   input  mcfir_pkg::status_type                 status,
   output mcfir_pkg::cmd_type                    cmd
);

   mcfir_pkg::state_type state_ff, state_in;
   logic                 accept;

   assign req_ready = (state_ff == mcfir_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in          = state_ff;
      cmd               = '0;
      case (state_ff)
         mcfir_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_type == mcfir_pkg::REQ_COEF) begin
                  cmd.accept_coef = 1'b1;
               end else begin
                  cmd.accept_sample = 1'b1;
                  state_in = status.zero_taps ? mcfir_pkg::ST_DRAIN : mcfir_pkg::ST_RUN;
               end
            end
         end
         mcfir_pkg::ST_RUN: begin
            cmd.step = 1'b1;
            if (status.last_tap) begin
               state_in = mcfir_pkg::ST_DRAIN;
            end
         end
         mcfir_pkg::ST_DRAIN: begin
            if (!status.pipe_busy && status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = mcfir_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mcfir_pkg::ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcfir_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/mcfir_datapath.sv]
// mcfir_datapath: coefficient and history memories, tap counter, mac pipeline, output register
// depends on mcfir_pkg for widths, command and status types
`timescale 1ns / 1ps

module mcfir_datapath #(
   parameter int MAX_TAPS = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_wr_en,
   input  logic [mcfir_pkg::TAP_COUNT_W-1:0]        csr_wr_data,
   input  logic [mcfir_pkg::COEF_IDX_W-1:0]         coef_index,
   input  logic signed [mcfir_pkg::COEF_W-1:0]      coef_value,
   input  logic signed [mcfir_pkg::SAMPLE_W-1:0]    sample_value,
   input  logic                                     channel_start,
   input  mcfir_pkg::cmd_type                       cmd,
   output mcfir_pkg::status_type                    status,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [mcfir_pkg::RESULT_W-1:0]    rsp_value
);

   localparam int ADDR_W    = $clog2(MAX_TAPS);
   localparam int HIST_D    = 2 ** ADDR_W;
   localparam int CNT_W     = $clog2(MAX_TAPS + 1);
   localparam int WIDE_W    = ADDR_W + mcfir_pkg::COEF_IDX_W;

   // memories
   logic signed [mcfir_pkg::COEF_W-1:0]   coef_mem [MAX_TAPS];
   logic signed [mcfir_pkg::SAMPLE_W-1:0] hist_mem [HIST_D];

   // control registers
   logic [mcfir_pkg::TAP_COUNT_W-1:0] tap_count_ff;
   logic [CNT_W-1:0]                  taps_ff, taps_in;
   logic [CNT_W-1:0]                  k_ff;
   logic [CNT_W-1:0]                  fill_ff, fill_base, fill_in;
   logic [ADDR_W-1:0]                 wp_ff;
   logic                              rd_vld_ff, prod_vld_ff;
   logic                              rsp_valid_ff;

   // datapath registers
   logic signed [mcfir_pkg::COEF_W-1:0]   coef_rd_ff;
   logic signed [mcfir_pkg::SAMPLE_W-1:0] hist_rd_ff;
   logic                                  tap_ok_ff;
   logic signed [mcfir_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [mcfir_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic signed [mcfir_pkg::RESULT_W-1:0] rsp_value_ff;

   logic [WIDE_W-1:0] coef_wide;
   logic [ADDR_W-1:0] coef_waddr;
   logic              coef_in_range;
   logic [ADDR_W-1:0] hist_raddr;
   logic signed [mcfir_pkg::SAMPLE_W-1:0] hist_gated;

   // tap count saturated to the storage depth
   assign taps_in = (int'(tap_count_ff) > MAX_TAPS) ? CNT_W'(MAX_TAPS)
                                                    : CNT_W'(tap_count_ff);

   // history fill count including the new sample, capped at the depth
   assign fill_base = channel_start ? '0 : fill_ff;
   assign fill_in   = (int'(fill_base) >= MAX_TAPS) ? fill_base : fill_base + CNT_W'(1);

   // coefficient write address and range check
   assign coef_wide     = WIDE_W'(coef_index);
   assign coef_waddr    = coef_wide[ADDR_W-1:0];
   assign coef_in_range = (int'(coef_index) < MAX_TAPS);

   // delayed sample k sits k slots behind the newest write
   assign hist_raddr = wp_ff - ADDR_W'(1) - k_ff[ADDR_W-1:0];

   // status back to the controller
   assign status.zero_taps = (taps_in == '0);
   assign status.last_tap  = ((k_ff + CNT_W'(1)) == taps_ff);
   assign status.pipe_busy = rd_vld_ff || prod_vld_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // tap count register
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= mcfir_pkg::TAP_COUNT_RESET;
      end else if (csr_wr_en) begin
         tap_count_ff <= csr_wr_data;
      end
   end

   // coefficient memory, registered read at the tap counter
   always_ff @(posedge clock) begin
      if (cmd.accept_coef && coef_in_range) begin
         coef_mem[coef_waddr] <= coef_value;
      end
      if (cmd.step) begin
         coef_rd_ff <= coef_mem[k_ff[ADDR_W-1:0]];
      end
   end

   // history ring buffer, written on each sample, registered read per tap
   always_ff @(posedge clock) begin
      if (cmd.accept_sample) begin
         hist_mem[wp_ff] <= sample_value;
      end
      if (cmd.step) begin
         hist_rd_ff <= hist_mem[hist_raddr];
         tap_ok_ff  <= (k_ff < fill_ff);
      end
   end

   // ring pointer, fill count, tap counter and pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         fill_ff     <= '0;
         taps_ff     <= '0;
         k_ff        <= '0;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         if (cmd.accept_sample) begin
            wp_ff   <= wp_ff + ADDR_W'(1);
            fill_ff <= fill_in;
            taps_ff <= taps_in;
            k_ff    <= '0;
         end else if (cmd.step) begin
            k_ff <= k_ff + CNT_W'(1);
         end
         rd_vld_ff   <= cmd.step;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   // multiply stage, history taps before the channel start count as zero
   assign hist_gated = tap_ok_ff ? hist_rd_ff : '0;
   assign prod_in    = coef_rd_ff * hist_gated;

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         prod_ff <= prod_in;
      end
   end

   // accumulate stage
   assign acc_in = acc_ff + mcfir_pkg::ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (cmd.accept_sample) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   // output register, floor shift of the accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_value_ff <= acc_ff[mcfir_pkg::FRAC_W +: mcfir_pkg::RESULT_W];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

[src/multichannel_fir_filter.sv]
// a coefficient write gives no result
// a sample's result is loaded once the mac pipeline is empty and the output is free
// no new item is accepted until that result is loaded: one shared multiply-accumulate
// visits the taps one a cycle, tap_count saturated to MAX_TAPS
// reset (synchronous, active high) sets tap_count to 1 and empties the sample history
// coefficients are undefined until written
// depends on mcfir_pkg, mcfir_req_if, mcfir_rsp_if, mcfir_ctrl and mcfir_datapath
`timescale 1ns / 1ps

module multichannel_fir_filter #(
   parameter int MAX_TAPS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   mcfir_req_if.sink                             req_chan,
   mcfir_rsp_if.source                           rsp_chan,
   input  logic                                  csr_wr_en,
   input  logic [mcfir_pkg::TAP_COUNT_W-1:0]     csr_wr_data
);

   mcfir_pkg::cmd_type    cmd;
   mcfir_pkg::status_type status;
   logic                  req_ready;

   assign req_chan.ready = req_ready;

   // sequencer
   mcfir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // memories, mac pipeline and output register
   mcfir_datapath #(
      .MAX_TAPS (MAX_TAPS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .coef_index    (req_chan.coef_index),
      .coef_value    (req_chan.coef_value),
      .sample_value  (req_chan.sample_value),
      .channel_start (req_chan.channel_start),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_value     (rsp_chan.filtered_value)
   );

endmodule

[tb/multichannel_fir_filter_tb.sv]
// multichannel_fir_filter_tb: self-checking testbench for the multichannel fir filter
// drives coefficient writes and samples, predicts each filtered value and checks it in order
// depends on mcfir_pkg, mcfir_req_if, mcfir_rsp_if and multichannel_fir_filter
`timescale 1ns / 1ps

module multichannel_fir_filter_tb;

   localparam int FIR_TAPS    = 32;
   localparam int SETTLE_CYC  = FIR_TAPS + 12;
   localparam int STUCK_LIMIT = 3000;
   localparam int NUM_PHASES  = 12;
   localparam int PHASE_ITEMS = 100;

   typedef struct {
      logic [mcfir_pkg::REQ_TYPE_W-1:0]      kind;
      logic [mcfir_pkg::COEF_IDX_W-1:0]      tap;
      logic signed [mcfir_pkg::COEF_W-1:0]   coef;
      logic signed [mcfir_pkg::SAMPLE_W-1:0] sample;
      logic                                  first;
   } fir_req_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              csr_wr_en;
   logic [mcfir_pkg::TAP_COUNT_W-1:0] csr_wr_data;

   mcfir_req_if req_chan ();
   mcfir_rsp_if rsp_chan ();

   multichannel_fir_filter #(
      .MAX_TAPS(FIR_TAPS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // pending items, expected filtered values and the predictor state
   fir_req_type                           req_pending_q[$];
   logic signed [mcfir_pkg::RESULT_W-1:0] filtered_exp_q[$];
   logic signed [mcfir_pkg::COEF_W-1:0]   coef_tbl[FIR_TAPS];
   logic signed [mcfir_pkg::SAMPLE_W-1:0] sample_hist[FIR_TAPS-1];
   logic [mcfir_pkg::TAP_COUNT_W-1:0]     tap_cfg = mcfir_pkg::TAP_COUNT_RESET;

   int pushed_cnt   = 0;
   int accepted_cnt = 0;
   int sample_cnt   = 0;
   int coef_cnt     = 0;
   int result_cnt   = 0;
   int setting_cnt  = 0;
   int mismatch_cnt = 0;
   int stuck_cycles = 0;
   int burst_left   = 0;
   int gap_left     = 0;
   int pat_age      = 0;
   logic [15:0] ready_pat = 16'hffff;

   wire req_fire = req_chan.valid && req_chan.ready;
   wire rsp_fire = rsp_chan.valid && rsp_chan.ready;

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // filter predictor: updates coefficients and history, queues the expected value
   function automatic void apply_request(fir_req_type r);
      logic signed [mcfir_pkg::ACC_W-1:0]    acc;
      logic signed [mcfir_pkg::ACC_W-1:0]    scaled;
      logic signed [mcfir_pkg::SAMPLE_W-1:0] s;
      int                                    taps;
      if (r.kind == mcfir_pkg::REQ_COEF) begin
         coef_tbl[r.tap] = r.coef;
         coef_cnt++;
         return;
      end
      if (r.first) begin
         for (int k = 0; k < FIR_TAPS - 1; k++) sample_hist[k] = '0;
      end
      taps = (tap_cfg > FIR_TAPS) ? FIR_TAPS : int'(tap_cfg);
      acc = '0;
      for (int k = 0; k < taps; k++) begin
         if (k == 0) s = r.sample;
         else s = sample_hist[k-1];
         acc = acc + coef_tbl[k] * s;
      end
      for (int k = FIR_TAPS - 2; k > 0; k--) sample_hist[k] = sample_hist[k-1];
      sample_hist[0] = r.sample;
      scaled = acc >>> mcfir_pkg::FRAC_W;
      filtered_exp_q.push_back(scaled[mcfir_pkg::RESULT_W-1:0]);
      sample_cnt++;
   endfunction

   // random 16-bit value, biased toward the extremes
   function automatic logic signed [15:0] rand_s16(bit extreme);
      if (extreme || $urandom_range(0, 5) == 0) begin
         case ($urandom_range(0, 4))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return 16'sh0001;
         endcase
      end
      return 16'($urandom);
   endfunction

   task automatic push_coef(input int idx, input logic signed [mcfir_pkg::COEF_W-1:0] val);
      fir_req_type r;
      r.kind   = mcfir_pkg::REQ_COEF;
      r.tap    = idx[mcfir_pkg::COEF_IDX_W-1:0];
      r.coef   = val;
      r.sample = 16'($urandom);
      r.first  = 1'($urandom_range(0, 1));
      req_pending_q.push_back(r);
      pushed_cnt++;
   endtask

   task automatic push_sample(input logic signed [mcfir_pkg::SAMPLE_W-1:0] val,
                              input logic first);
      fir_req_type r;
      r.kind   = mcfir_pkg::REQ_SAMPLE;
      r.tap    = 5'($urandom);
      r.coef   = 16'($urandom);
      r.sample = val;
      r.first  = first;
      req_pending_q.push_back(r);
      pushed_cnt++;
   endtask

   // wait until every item is taken and every result is back, then let the block drain
   task automatic wait_idle();
      while (accepted_cnt != pushed_cnt || filtered_exp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic set_taps(input int val);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= 6'(val);
      tap_cfg      = 6'(val);
      setting_cnt++;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // request driver: bursts of items with random gaps, prediction at acceptance
   always @(posedge clock) begin : req_driver
      fir_req_type nxt;
      fir_req_type took;
      if (reset) begin
         req_chan.valid         <= 1'b0;
         req_chan.req_type      <= mcfir_pkg::REQ_COEF;
         req_chan.coef_index    <= '0;
         req_chan.coef_value    <= '0;
         req_chan.sample_value  <= '0;
         req_chan.channel_start <= 1'b0;
      end else begin
         if (req_fire) begin
            took.kind   = req_chan.req_type;
            took.tap    = req_chan.coef_index;
            took.coef   = req_chan.coef_value;
            took.sample = req_chan.sample_value;
            took.first  = req_chan.channel_start;
            apply_request(took);
            accepted_cnt++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left != 0) begin
               req_chan.valid <= 1'b0;
               gap_left = gap_left - 1;
            end else if (req_pending_q.size() != 0) begin
               nxt = req_pending_q.pop_front();
               req_chan.valid         <= 1'b1;
               req_chan.req_type      <= nxt.kind;
               req_chan.coef_index    <= nxt.tap;
               req_chan.coef_value    <= nxt.coef;
               req_chan.sample_value  <= nxt.sample;
               req_chan.channel_start <= nxt.first;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left = burst_left - 1;
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // result ready follows a rotating pattern, reloaded with a new stall mode now and then
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ready_pat[0];
         if (pat_age == 0) begin
            case ($urandom_range(0, 3))
               0: ready_pat = 16'hffff;
               1: ready_pat = 16'($urandom);
               2: ready_pat = 16'($urandom | $urandom);
               default: ready_pat = 16'($urandom & $urandom);
            endcase
            ready_pat[$urandom_range(0, 15)] = 1'b1;
            pat_age = $urandom_range(20, 120);
         end else begin
            ready_pat = {ready_pat[0], ready_pat[15:1]};
            pat_age   = pat_age - 1;
         end
      end
   end

   // result checker
   always @(posedge clock) begin : rsp_monitor
      logic signed [mcfir_pkg::RESULT_W-1:0] want;
      if (!reset && rsp_fire) begin
         result_cnt++;
         if (filtered_exp_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("unexpected result: filtered_value %0d with no sample pending",
                        rsp_chan.filtered_value);
         end else begin
            want = filtered_exp_q.pop_front();
            if (rsp_chan.filtered_value !== want) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("result %0d: filtered_value expected %0d, got %0d",
                           result_cnt, want, rsp_chan.filtered_value);
            end
         end
      end
   end

   // watchdog on cycles without any accepted item or result
   always @(posedge clock) begin
      if (reset || req_fire || rsp_fire) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("timeout: no item accepted for %0d cycles", stuck_cycles);
         $display("Some tests failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // stimulus
   initial begin : stimulus
      int  phase_items;
      int  ch_len;
      int  pick;
      int  setting;
      bit  extreme;
      req_chan.valid         = 1'b0;
      req_chan.req_type      = mcfir_pkg::REQ_COEF;
      req_chan.coef_index    = '0;
      req_chan.coef_value    = '0;
      req_chan.sample_value  = '0;
      req_chan.channel_start = 1'b0;
      rsp_chan.ready         = 1'b0;
      csr_wr_en              = 1'b0;
      csr_wr_data            = '0;
      reset                  = 1'b1;
      for (int k = 0; k < FIR_TAPS; k++) coef_tbl[k] = '0;
      for (int k = 0; k < FIR_TAPS - 1; k++) sample_hist[k] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // load every tap before the first sample, extremes on the first two
      push_coef(0, 16'sh8000);
      push_coef(1, 16'sh7fff);
      for (int k = 2; k < FIR_TAPS; k++) push_coef(k, rand_s16(1'b0));

      // single tap after reset: sample extremes and floor of negative sums
      push_sample(16'sh7fff, 1'b1);
      push_sample(16'sh8000, 1'b0);
      push_sample(16'shffff, 1'b0);
      push_sample(16'sh0000, 1'b0);
      push_coef(0, 16'sh0001);
      push_sample(16'shffff, 1'b0);
      push_sample(16'sh0001, 1'b0);
      wait_idle();

      // no active taps: zero output while the history keeps moving
      set_taps(0);
      push_sample(16'sh3039, 1'b0);
      push_sample(16'sh8000, 1'b0);
      wait_idle();

      // tap count beyond the array saturates to the full length
      set_taps(63);
      push_sample(16'sh7fff, 1'b0);
      push_sample(16'shfffe, 1'b0);
      push_sample(16'sh8000, 1'b1);
      wait_idle();

      // full length, coefficient write in mid-channel leaves the history alone
      set_taps(FIR_TAPS);
      push_sample(16'sh0007, 1'b0);
      push_coef(5, 16'sh8000);
      push_sample(16'sh7fff, 1'b0);
      push_sample(16'sh0064, 1'b1);
      wait_idle();

      // random phases of channel-major streams
      for (int p = 0; p < NUM_PHASES; p++) begin
         extreme = (p == 2 || p == 7);
         if (p == 2) begin
            setting = FIR_TAPS;
         end else if (p == 7) begin
            setting = 63;
         end else begin
            pick = $urandom_range(0, 9);
            if (pick == 0) setting = $urandom_range(FIR_TAPS + 1, 63);
            else if (pick == 1) setting = 0;
            else if (pick == 2) setting = FIR_TAPS;
            else setting = $urandom_range(1, FIR_TAPS - 1);
         end
         set_taps(setting);

         if (extreme) begin
            for (int k = 0; k < FIR_TAPS; k++) push_coef(k, rand_s16(1'b1));
         end else begin
            repeat ($urandom_range(1, 8))
               push_coef($urandom_range(0, FIR_TAPS - 1), rand_s16(1'b0));
         end

         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            ch_len = ($urandom_range(0, 3) == 0) ? $urandom_range(FIR_TAPS + 1, 48)
                                                 : $urandom_range(1, FIR_TAPS);
            for (int j = 0; j < ch_len; j++) begin
               if ($urandom_range(0, 11) == 0) begin
                  push_coef($urandom_range(0, FIR_TAPS - 1), rand_s16(extreme));
                  phase_items++;
               end
               // a stray channel start now and then breaks a channel short
               push_sample(rand_s16(extreme), (j == 0) || ($urandom_range(0, 29) == 0));
               phase_items++;
            end
         end
         wait_idle();
      end

      $display("run covered %0d samples and %0d coefficient writes over %0d tap settings",
               sample_cnt, coef_cnt, setting_cnt);
      $display("%0d results checked, %0d mismatches", result_cnt, mismatch_cnt);
      if (mismatch_cnt == 0 && filtered_exp_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[files.f]
src/mcfir_pkg.sv
src/mcfir_req_if.sv
src/mcfir_rsp_if.sv
src/mcfir_ctrl.sv
src/mcfir_datapath.sv
src/multichannel_fir_filter.sv
tb/multichannel_fir_filter_tb.sv
